// ----- hdl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the greedy box NMS unit
// Payload structs, kept-table sizing and arithmetic widths.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int MAX_KEPT   = 64;
   localparam int KEPT_IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int KEPT_CNT_W = $clog2(MAX_KEPT + 1);

   localparam int THR_W = 9;
   localparam int NUM_W = 16;
   localparam int AREA_W = 30;   // 15 x 15 bit width*height
   localparam int INTER_W = 31;  // intersection sides reach 32767 + one pixel

   localparam logic [THR_W-1:0] THR_RESET = 9'd102;
   localparam logic signed [17:0] PIXEL_ONE = 18'sd16;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
      logic               set_start;
   } req_payload_type;

   typedef struct packed {
      logic             keep;
      logic [NUM_W-1:0] box_number;
      logic             table_full;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
   } box_type;

   typedef struct packed {
      logic busy;  // any stage holds a comparison
      logic hit;   // last stage found an overlap above threshold
   } pipe_status_type;

endpackage

// ----- hdl/gbn_ram.sv -----
// ----------------------------------------------------------------------------
// gbn_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gbn_iou_pipe.sv -----
// ----------------------------------------------------------------------------
// gbn_iou_pipe: pipelined overlap test, one kept box per cycle
// Intersection with the +1 pixel rule, union from plain areas, and the
// division-free test inter*256 > thr*union. Five stages.
// ----------------------------------------------------------------------------
module gbn_iou_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,  // RAM data valid next cycle
   input  gbn_pkg::box_type                 kept_box,  // registered RAM output
   input  gbn_pkg::box_type                 cur_box,
   input  logic [gbn_pkg::AREA_W-1:0]       cur_area,
   input  logic [gbn_pkg::THR_W-1:0]        thr,
   output gbn_pkg::pipe_status_type         status
);

   // stage valids
   logic p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;

   // stage 1: sides of the intersection
   logic signed [16:0] cl, cr, ct, cb, kl, kr, kt, kb;
   logic signed [16:0] x1, x2, y1, y2;
   logic signed [17:0] dx, dy;
   logic [15:0] w_in, h_in;
   logic [15:0] w_ff, h_ff;
   logic [gbn_pkg::AREA_W-1:0] area_b_ff, area_b_in;

   // stage 2..5
   logic [gbn_pkg::INTER_W-1:0] inter2_ff, inter3_ff, inter4_ff;
   logic [gbn_pkg::INTER_W-1:0] sum_ff;
   logic signed [31:0] uni_in, uni_ff;
   logic [gbn_pkg::INTER_W+8:0] prod_ff;
   logic neg4_ff;
   logic [gbn_pkg::INTER_W+8:0] lhs;

   always_comb begin
      cl = {cur_box.box_left[15], cur_box.box_left};
      ct = {cur_box.box_top[15], cur_box.box_top};
      kl = {kept_box.box_left[15], kept_box.box_left};
      kt = {kept_box.box_top[15], kept_box.box_top};
      cr = cl + $signed({2'b00, cur_box.box_width});
      cb = ct + $signed({2'b00, cur_box.box_height});
      kr = kl + $signed({2'b00, kept_box.box_width});
      kb = kt + $signed({2'b00, kept_box.box_height});
      x1 = (cl > kl) ? cl : kl;
      y1 = (ct > kt) ? ct : kt;
      x2 = (cr < kr) ? cr : kr;
      y2 = (cb < kb) ? cb : kb;
      dx = {x2[16], x2} - {x1[16], x1} + gbn_pkg::PIXEL_ONE;
      dy = {y2[16], y2} - {y1[16], y1} + gbn_pkg::PIXEL_ONE;
      // sides never exceed the narrower box plus one pixel
      w_in = dx[17] ? 16'd0 : dx[15:0];
      h_in = dy[17] ? 16'd0 : dy[15:0];
      area_b_in = kept_box.box_width * kept_box.box_height;
      // area sum and intersection of the same kept box sit side by side here
      uni_in = $signed({1'b0, sum_ff}) - $signed({1'b0, inter2_ff});
      lhs = {1'b0, inter4_ff, 8'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         p3_ff <= 1'b0;
         p4_ff <= 1'b0;
         p5_ff <= 1'b0;
      end else begin
         p1_ff <= in_valid;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
         p5_ff <= p4_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      h_ff      <= h_in;
      area_b_ff <= area_b_in;
      inter2_ff <= gbn_pkg::INTER_W'(w_ff * h_ff);
      sum_ff    <= gbn_pkg::INTER_W'({1'b0, cur_area} + {1'b0, area_b_ff});
      inter3_ff <= inter2_ff;
      uni_ff    <= uni_in;
      inter4_ff <= inter3_ff;
      neg4_ff   <= uni_ff[31];
      prod_ff   <= thr * uni_ff[30:0];
   end

   // a negative union never suppresses; zero union suppresses on any overlap
   assign status.hit  = p5_ff && !neg4_ff && (lhs > prod_ff);
   assign status.busy = p1_ff | p2_ff | p3_ff | p4_ff | p5_ff;

endmodule

// ----- hdl/greedy_box_nms_unit.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms_unit: greedy non-maximum suppression by IoU
// Each box is tested against every kept box of its set; survivors are stored
// in the kept table until it is full.
//
//   channel  direction  handshake      payload
//   req      in         valid/stall    gbn_pkg::req_payload_type
//   rsp      out        valid/stall    gbn_pkg::rsp_payload_type
//   csr      in         valid/ready    9-bit overlap threshold
//
// Each box makes one read of the kept-table RAM per kept box into the
// five-stage overlap pipe, then the pipe drains.
// Reset clears the threshold to 102 and empties the table and box counter.
// req_stall is high from acceptance until the result is loaded; a stalled
// result holds in the output register while the next box is taken.
// ----------------------------------------------------------------------------
module greedy_box_nms_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gbn_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gbn_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gbn_pkg::THR_W-1:0]     csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [gbn_pkg::THR_W-1:0] thr_ff;
   logic [gbn_pkg::KEPT_CNT_W-1:0] kept_count_ff, kept_count_in;
   logic [gbn_pkg::KEPT_CNT_W-1:0] issue_ff, issue_in;
   logic [gbn_pkg::NUM_W-1:0] box_counter_ff, box_counter_in;
   logic [gbn_pkg::NUM_W-1:0] number_ff, number_in;
   logic suppress_ff, suppress_in;
   gbn_pkg::box_type cur_box_ff, cur_box_in;
   logic [gbn_pkg::AREA_W-1:0] cur_area_ff, cur_area_in;
   logic rsp_valid_ff, rsp_valid_in;
   gbn_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic req_xfer, rd_en, wr_en, out_free, keep, full;
   gbn_pkg::box_type kept_box;
   gbn_pkg::pipe_status_type pipe_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign keep      = !suppress_ff;
   assign full      = keep && (kept_count_ff == gbn_pkg::KEPT_CNT_W'(gbn_pkg::MAX_KEPT));
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < kept_count_ff);
   assign wr_en     = (state_ff == ST_DONE) && out_free && keep && !full;

   always_comb begin
      state_in       = state_ff;
      kept_count_in  = kept_count_ff;
      issue_in       = issue_ff;
      box_counter_in = box_counter_ff;
      number_in      = number_ff;
      suppress_in    = suppress_ff | pipe_status.hit;
      cur_box_in     = cur_box_ff;
      cur_area_in    = cur_area_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cur_box_in.box_left   = req_payload.box_left;
               cur_box_in.box_top    = req_payload.box_top;
               cur_box_in.box_width  = req_payload.box_width;
               cur_box_in.box_height = req_payload.box_height;
               cur_area_in = req_payload.box_width * req_payload.box_height;
               number_in   = req_payload.set_start ? '0 : box_counter_ff;
               box_counter_in = number_in + 1'b1;
               if (req_payload.set_start) begin
                  kept_count_in = '0;
               end
               issue_in    = '0;
               suppress_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end else if (!pipe_status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.keep       = keep;
               rsp_payload_in.box_number = number_ff;
               rsp_payload_in.table_full = full;
               if (wr_en) begin
                  kept_count_in = kept_count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         thr_ff         <= gbn_pkg::THR_RESET;
         kept_count_ff  <= '0;
         issue_ff       <= '0;
         box_counter_ff <= '0;
         suppress_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kept_count_ff  <= kept_count_in;
         issue_ff       <= issue_in;
         box_counter_ff <= box_counter_in;
         suppress_ff    <= suppress_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      number_ff      <= number_in;
      cur_box_ff     <= cur_box_in;
      cur_area_ff    <= cur_area_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   gbn_ram #(
      .WIDTH ($bits(gbn_pkg::box_type)),
      .DEPTH (gbn_pkg::MAX_KEPT)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (kept_count_ff[gbn_pkg::KEPT_IDX_W-1:0]),
      .wr_data (cur_box_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[gbn_pkg::KEPT_IDX_W-1:0]),
      .rd_data (kept_box)
   );

   gbn_iou_pipe u_iou_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_en),
      .kept_box (kept_box),
      .cur_box  (cur_box_ff),
      .cur_area (cur_area_ff),
      .thr      (thr_ff),
      .status   (pipe_status)
   );

   // kept table never overflows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= gbn_pkg::KEPT_CNT_W'(gbn_pkg::MAX_KEPT))
      else $error("kept count beyond table depth");

   // overlap pipe only works during a scan
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      pipe_status.busy |-> (state_ff == ST_SCAN))
      else $error("overlap pipe busy outside scan");

   // a result transfer out of DONE always returns to idle
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result not loaded on finish");

   // full flag only accompanies a kept box
   a_full_keep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.table_full) |-> rsp_payload_ff.keep)
      else $error("table_full without keep");

endmodule

// ----- test/tb_greedy_box_nms_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_box_nms_unit: self-checking bench for the greedy box NMS unit
// Boxes go in through the req channel and an in-bench IoU predictor computes
// the keep / box number / table-full result of each one. Results are checked
// in order. Covered: edge-case geometry, a threshold sweep with the extremes,
// kept-table overflow, long output back-pressure and random sets.
// ----------------------------------------------------------------------------
module tb_greedy_box_nms_unit;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = gbn_pkg::MAX_KEPT + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   gbn_pkg::req_payload_type      req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b1;
   gbn_pkg::rsp_payload_type      rsp_payload;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [gbn_pkg::THR_W-1:0]     csr_data    = '0;

   greedy_box_nms_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [gbn_pkg::THR_W-1:0] thr_model = gbn_pkg::THR_RESET;
   gbn_pkg::box_type          kept_store[gbn_pkg::MAX_KEPT];
   int                        kept_total = 0;
   logic [gbn_pkg::NUM_W-1:0] set_position = '0;

   gbn_pkg::rsp_payload_type  expected_results[$];
   gbn_pkg::rsp_payload_type  checked_want;

   int  mismatch_count   = 0;
   int  results_checked  = 0;
   int  boxes_sent       = 0;
   int  kept_seen        = 0;
   int  suppressed_seen  = 0;
   int  full_seen        = 0;
   int  threshold_writes = 0;
   int  holds_done       = 0;
   int  quiet_cycles     = 0;
   int  hold_request     = 0;
   bit  sender_idle      = 1'b1;
   bit  receiver_idle    = 1'b1;

   function automatic bit overlap_too_large(gbn_pkg::box_type a, gbn_pkg::box_type b);
      longint al, at, aw, ah, bl, bt, bw, bh;
      longint x1, y1, x2, y2, iw, ih, inter, uni;
      al = longint'($signed(a.box_left));
      at = longint'($signed(a.box_top));
      aw = longint'(a.box_width);
      ah = longint'(a.box_height);
      bl = longint'($signed(b.box_left));
      bt = longint'($signed(b.box_top));
      bw = longint'(b.box_width);
      bh = longint'(b.box_height);
      x1 = (al > bl) ? al : bl;
      y1 = (at > bt) ? at : bt;
      x2 = (al + aw < bl + bw) ? al + aw : bl + bw;
      y2 = (at + ah < bt + bh) ? at + ah : bt + bh;
      // +1 pixel rule on the intersection only
      iw = x2 - x1 + longint'(gbn_pkg::PIXEL_ONE);
      ih = y2 - y1 + longint'(gbn_pkg::PIXEL_ONE);
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = aw * ah + bw * bh - inter;
      if (uni < 0) return 1'b0;
      return inter * 256 > longint'(thr_model) * uni;
   endfunction

   function automatic gbn_pkg::rsp_payload_type predict_nms(gbn_pkg::req_payload_type b);
      gbn_pkg::rsp_payload_type r;
      gbn_pkg::box_type         cur;
      bit                       suppressed;
      int                       i;
      cur.box_left   = b.box_left;
      cur.box_top    = b.box_top;
      cur.box_width  = b.box_width;
      cur.box_height = b.box_height;
      if (b.set_start) begin
         kept_total = 0;
         set_position = '0;
      end
      r.box_number = set_position;
      set_position = set_position + 1'b1;
      suppressed = 1'b0;
      for (i = 0; i < kept_total; i++)
         if (overlap_too_large(cur, kept_store[i])) suppressed = 1'b1;
      r.keep = !suppressed;
      r.table_full = 1'b0;
      if (!suppressed) begin
         if (kept_total < gbn_pkg::MAX_KEPT) begin
            kept_store[kept_total] = cur;
            kept_total++;
         end else begin
            r.table_full = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic gbn_pkg::req_payload_type mk_box(int l, int t, int w, int h, bit s);
      gbn_pkg::req_payload_type b;
      b.box_left   = 16'(l);
      b.box_top    = 16'(t);
      b.box_width  = 15'(w);
      b.box_height = 15'(h);
      b.set_start  = s;
      return b;
   endfunction

   function automatic gbn_pkg::req_payload_type jitter_box(int cx, int cy, int w, int h);
      int jx, jy;
      jx = w / 8 + 1;
      jy = h / 8 + 1;
      return mk_box(cx + int'($urandom_range(0, 2 * jx)) - jx,
                    cy + int'($urandom_range(0, 2 * jy)) - jy,
                    w + int'($urandom_range(0, 2 * jx)) - jx,
                    h + int'($urandom_range(0, 2 * jy)) - jy, 1'b0);
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, gbn_pkg::rsp_payload_type want,
                                  gbn_pkg::rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected keep=%0b number=%0d full=%0b",
                  what, want.keep, want.box_number, want.table_full,
                  ", got keep=%0b number=%0d full=%0b",
                  got.keep, got.box_number, got.table_full);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("no transfer expected", '0, rsp_payload);
         end else begin
            checked_want = expected_results.pop_front();
            if (rsp_payload.keep !== checked_want.keep ||
                rsp_payload.box_number !== checked_want.box_number ||
                rsp_payload.table_full !== checked_want.table_full)
               report_mismatch("field", checked_want, rsp_payload);
         end
         results_checked++;
         if (rsp_payload.table_full === 1'b1) full_seen++;
         if (rsp_payload.keep === 1'b1) kept_seen++;
         else suppressed_seen++;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                  quiet_cycles, expected_results.size());
         $display("[greedy_box_nms_unit] ERROR");
         $finish;
      end
   end

   // result receiver: random stalls plus requested long hold-offs
   initial begin : result_sink
      int stall_len;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall_len = hold_request;
            hold_request = 0;
            holds_done++;
         end else begin
            stall_len = receiver_idle ? idle_length() : 0;
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic send_box(gbn_pkg::req_payload_type b);
      int gap;
      gbn_pkg::rsp_payload_type want;
      gap = sender_idle ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_nms(b);
      expected_results = {expected_results, want};
      boxes_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(logic [gbn_pkg::THR_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      thr_model = value;
      threshold_writes++;
   endtask

   task automatic test_directed();
      // first set opens at reset without a start flag
      send_box(mk_box(0, 0, 160, 160, 1'b0));
      send_box(mk_box(0, 0, 160, 160, 1'b0));
      send_box(mk_box(8, 8, 160, 160, 1'b0));
      send_box(mk_box(-32768, -32768, 32767, 32767, 1'b0));
      send_box(mk_box(32767, 32767, 32767, 32767, 1'b0));
      // zero-size boxes on the same spot: negative union, never suppressed
      send_box(mk_box(1000, 1000, 0, 0, 1'b0));
      send_box(mk_box(1000, 1000, 0, 0, 1'b0));
      // zero union with overlap suppresses; zero union without it does not
      send_box(mk_box(5000, 5000, 16, 16, 1'b1));
      send_box(mk_box(5000, 5000, 0, 0, 1'b0));
      send_box(mk_box(9000, 9000, 0, 0, 1'b0));
      send_box(mk_box(20000, 20000, 0, 0, 1'b0));
      send_box(mk_box(-1, -1, 1, 1, 1'b1));
      send_box(mk_box(-32768, 32767, 0, 32767, 1'b0));
      send_box(mk_box(32767, -32768, 32767, 0, 1'b0));
      send_box(mk_box(-2, -2, 32767, 32767, 1'b0));
      drain_results();
   endtask

   task automatic test_threshold_sweep();
      logic [gbn_pkg::THR_W-1:0] levels[7] =
         '{9'd0, 9'd1, 9'd255, 9'd256, 9'd300, 9'd511, 9'd170};
      int cx, cy, w, h, k;
      foreach (levels[i]) begin
         set_threshold(levels[i]);
         cx = int'($urandom_range(0, 50000)) - 25000;
         cy = int'($urandom_range(0, 50000)) - 25000;
         w = $urandom_range(16, 200);
         h = $urandom_range(16, 200);
         send_box(mk_box(cx, cy, w, h, 1'b1));
         for (k = 0; k < 11; k++)
            send_box(jitter_box((k % 2) ? cx + w / 2 : cx, cy, w, h));
      end
      drain_results();
   endtask

   task automatic test_table_full();
      int i;
      // 70 disjoint boxes: the last six are kept but cannot be stored
      for (i = 0; i < 70; i++)
         send_box(mk_box(-30000 + (i % 10) * 5000, -30000 + (i / 10) * 5000, 800, 800,
                         i == 0));
      send_box(mk_box(-30000, -30000, 800, 800, 1'b0));
      // same place as an unstored box: still kept with the full flag
      send_box(mk_box(-10000, 0, 800, 800, 1'b0));
      send_box(mk_box(-30000, -30000, 800, 800, 1'b1));
      send_box(mk_box(-10000, 0, 800, 800, 1'b0));
      drain_results();
   endtask

   task automatic test_back_pressure();
      int k, cx, cy;
      cx = int'($urandom_range(0, 40000)) - 20000;
      cy = int'($urandom_range(0, 40000)) - 20000;
      sender_idle = 1'b0;
      hold_request = 400;
      send_box(mk_box(cx, cy, 600, 400, 1'b1));
      for (k = 0; k < 11; k++)
         send_box(jitter_box(cx + k * 300, cy, 600, 400));
      // sender waits until every result is back
      drain_results();
      sender_idle = 1'b1;
      for (k = 0; k < 8; k++)
         send_box(jitter_box(cx, cy + k * 200, 600, 400));
      drain_results();
   endtask

   task automatic test_random_sets(int target);
      int done_boxes, sets, r, set_len, n_clusters, c, k;
      int cl_x[6], cl_y[6], cl_w[6], cl_h[6];
      gbn_pkg::req_payload_type b;
      done_boxes = 0;
      sets = 0;
      while (done_boxes < target) begin
         if (sets % 6 == 5)
            set_threshold(($urandom_range(0, 9) < 7) ? 9'($urandom_range(60, 200))
                                                     : 9'($urandom_range(0, 511)));
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 9);
         set_len = (r < 7) ? $urandom_range(1, 20)
                 : (r < 9) ? $urandom_range(21, 45) : $urandom_range(60, 75);
         n_clusters = $urandom_range(1, 6);
         for (c = 0; c < 6; c++) begin
            cl_x[c] = int'($urandom_range(0, 56000)) - 30000;
            cl_y[c] = int'($urandom_range(0, 56000)) - 30000;
            cl_w[c] = $urandom_range(16, 4000);
            cl_h[c] = $urandom_range(16, 4000);
         end
         for (k = 0; k < set_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any field value, start flag anywhere
               b = mk_box(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          $urandom_range(0, 32767), $urandom_range(0, 32767),
                          $urandom_range(0, 1));
            end else if (set_len >= 60) begin
               // small scattered boxes, enough survivors to fill the table
               b = mk_box(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
            end else begin
               c = $urandom_range(0, n_clusters - 1);
               b = jitter_box(cl_x[c], cl_y[c], cl_w[c], cl_h[c]);
            end
            // some sets run on without a start flag
            if (k == 0) b.set_start = ($urandom_range(0, 9) != 0);
            send_box(b);
            done_boxes++;
         end
         sets++;
      end
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_sweep();
      test_table_full();
      test_back_pressure();
      test_random_sets(400);
      drain_results();
      $display("covered %0d boxes: %0d kept, %0d suppressed, %0d kept with table full",
               boxes_sent, kept_seen, suppressed_seen, full_seen);
      $display("%0d threshold writes, %0d long hold-offs, %0d mismatches",
               threshold_writes, holds_done, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[greedy_box_nms_unit] OK");
      end else begin
         $display("[greedy_box_nms_unit] ERROR");
      end
      $finish;
   end

endmodule
